@@ hw/rtl/wbc_pkg.sv @@
package wbc_pkg;

    // Field widths
    localparam int COUNT_W    = 6;
    localparam int MODE_W     = 2;
    localparam int PHASE_W    = 2;
    localparam int TENS_W     = 3;
    localparam int ONES_W     = 4;
    localparam int COL_W      = 9;
    localparam int KEY_W      = 4;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Divider sizing: span (COL_W bits) times elapsed (COUNT_W bits)
    localparam int DIVIDEND_W = COL_W + COUNT_W;
    localparam int DIVISOR_W  = COUNT_W;

    // Divide by ten: floor(c * 205 / 2048) is exact for every 6-bit count
    localparam int TENS_RECIP = 205;
    localparam int TENS_SHIFT = 11;
    localparam int TENS_PROD_W = 14;

    // Reset values of the registers and the timer state
    localparam logic [COUNT_W-1:0] WORK_LEN_RST  = COUNT_W'(25);
    localparam logic [COUNT_W-1:0] SHORT_LEN_RST = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] LONG_LEN_RST  = COUNT_W'(15);
    localparam logic [COL_W-1:0]   LEFT_COL_RST  = COL_W'(100);
    localparam logic [COL_W-1:0]   RIGHT_COL_RST = COL_W'(220);
    localparam logic [PHASE_W-1:0] PHASE_RST     = PHASE_W'(1);

    // Key value that starts, pauses or acknowledges
    localparam logic [KEY_W-1:0]   KEY_ACT       = KEY_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORK_LEN  = 3'd0,
        CFG_SHORT_LEN = 3'd1,
        CFG_LONG_LEN  = 3'd2,
        CFG_LEFT_COL  = 3'd3,
        CFG_RIGHT_COL = 3'd4
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_RING = 2'd2
    } t_mode;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_KEY  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

@@ hw/rtl/wbc_div.sv @@
module wbc_div import wbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output t_div_status           o_status
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

@@ hw/rtl/work_break_countdown_controller.sv @@
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: key_bits; tuser: cmd
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: remaining .. bar_end_column
// cfg       in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// From acceptance to a valid result an item goes through these steps: one updates the
// timer, one forms the bar product and the tens digit, one launches the divider,
// then 15 single-bit steps of the restoring divider, one to take the quotient
// and one to load the result. The next transaction is taken only after the result
// of the last one is loaded.
// A clamped bar skips the divider steps and goes straight to the load.
// s_axis_tready is high only while no item is in progress; a result that waits on
// m_axis_tready does not block the next transaction, only the load of its result.
// Reset (synchronous, active low) restores the registers and the timer state.
// The configuration port is always ready.
module work_break_countdown_controller import wbc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // [3:0] key_bits, [7:4] zero
    input  logic [0:0]             s_axis_tuser,   // [0] cmd

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [5:0] remaining, [7:6] run_mode, [8] on_break, [11:9] tens_digit,
    // [15:12] ones_digit, [24:16] bar_end_column, [31:25] zero
    output logic [M_TDATA_W-1:0]   m_axis_tdata,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    // Configuration registers
    logic [COUNT_W-1:0] r_work_len;
    logic [COUNT_W-1:0] r_short_len;
    logic [COUNT_W-1:0] r_long_len;
    logic [COL_W-1:0]   r_left_col;
    logic [COL_W-1:0]   r_right_col;

    // Timer state
    t_state             r_state;
    logic [COUNT_W-1:0] r_count;
    t_mode              r_mode;
    logic               r_break;
    logic [PHASE_W-1:0] r_phase;

    logic [COUNT_W-1:0] n_count;
    t_mode              n_mode;
    logic               n_break;
    logic [PHASE_W-1:0] n_phase;

    // Result computation
    logic [DIVIDEND_W-1:0] r_prod;
    logic                  r_skip;
    logic [TENS_W-1:0]     r_tens;
    logic [COL_W-1:0]      r_part;

    logic                  r_m_valid;
    logic [M_TDATA_W-1:0]  r_m_data;

    logic                  w_accept;
    logic                  w_right_ge;
    logic [COL_W-1:0]      w_span;
    logic [COUNT_W-1:0]    w_elapsed;
    logic [TENS_PROD_W-1:0] w_tens_prod;
    logic [ONES_W-1:0]     w_ones;
    logic [COL_W-1:0]      w_bar;
    logic                  w_out_free;

    logic [DIVIDEND_W-1:0] w_quotient;
    t_div_status           w_div_stat;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_len  <= WORK_LEN_RST;
            r_short_len <= SHORT_LEN_RST;
            r_long_len  <= LONG_LEN_RST;
            r_left_col  <= LEFT_COL_RST;
            r_right_col <= RIGHT_COL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WORK_LEN:  r_work_len  <= i_cfg_data[COUNT_W-1:0];
                CFG_SHORT_LEN: r_short_len <= i_cfg_data[COUNT_W-1:0];
                CFG_LONG_LEN:  r_long_len  <= i_cfg_data[COUNT_W-1:0];
                CFG_LEFT_COL:  r_left_col  <= i_cfg_data[COL_W-1:0];
                CFG_RIGHT_COL: r_right_col <= i_cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    // Timer update for the incoming transaction
    always_comb begin
        n_count = r_count;
        n_mode  = r_mode;
        n_break = r_break;
        n_phase = r_phase;
        if (t_cmd'(s_axis_tuser[0]) == CMD_TICK) begin
            // Count down only while running; ring once the count sits at zero
            if (r_mode == MODE_RUN) begin
                if (r_count != '0) begin
                    n_count = r_count - COUNT_W'(1);
                end
                if (n_count == '0) begin
                    n_mode = MODE_RING;
                end
            end
        end else if (s_axis_tdata[KEY_W-1:0] == KEY_ACT) begin
            unique case (r_mode)
                MODE_IDLE: n_mode = MODE_RUN;
                MODE_RUN:  n_mode = MODE_IDLE;
                MODE_RING: begin
                    // Acknowledge: flip period, advance session, reload the count and return to idle
                    n_break = !r_break;
                    n_phase = r_phase + PHASE_W'(1);
                    if (!n_break) begin
                        n_count = r_work_len;
                    end else if (n_phase != '0) begin
                        n_count = r_short_len;
                    end else begin
                        n_count = r_long_len;
                    end
                    n_mode = MODE_IDLE;
                end
                default: n_mode = r_mode;
            endcase
        end
    end

    // Bar operands (span, elapsed count), tens and ones digits, and the bar end column
    always_comb begin
        w_right_ge  = (r_right_col >= r_left_col);
        w_span      = w_right_ge ? (r_right_col - r_left_col) : (r_left_col - r_right_col);
        w_elapsed   = r_work_len - r_count;
        w_tens_prod = TENS_PROD_W'(r_count) * TENS_PROD_W'(TENS_RECIP);
        w_ones      = ONES_W'(7'(r_count) - (7'({r_tens, 3'b000}) + 7'({r_tens, 1'b0})));
        w_bar       = w_right_ge ? (r_left_col + r_part) : (r_left_col - r_part);
    end

    wbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START && !r_skip),
        .i_dividend (r_prod),
        .i_divisor  (r_work_len),
        .o_quotient (w_quotient),
        .o_status   (w_div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= WORK_LEN_RST;
            r_mode    <= MODE_IDLE;
            r_break   <= 1'b0;
            r_phase   <= PHASE_RST;
            r_m_valid <= 1'b0;
        end else begin
            // Drop the held result once the sink takes it, unless a new one replaces it
            if (r_m_valid && m_axis_tready && r_state != S_DONE) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= n_count;
                        r_mode  <= n_mode;
                        r_break <= n_break;
                        r_phase <= n_phase;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // Clamp to the left column when the work length is zero or the count exceeds it
                    r_skip  <= (r_work_len == '0) || (r_count > r_work_len);
                    r_prod  <= DIVIDEND_W'(w_span) * DIVIDEND_W'(w_elapsed);
                    r_tens  <= w_tens_prod[TENS_SHIFT +: TENS_W];
                    r_state <= S_START;
                end
                S_START: begin
                    if (r_skip) begin
                        r_part  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_part  <= w_quotient[COL_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free, then load the result
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= M_TDATA_W'({w_bar, w_ones, r_tens, r_break,
                                                 r_mode, r_count});
                        r_state   <= S_IDLE;
                    end else if (r_m_valid && m_axis_tready) begin
                        r_m_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // Ringing only ever happens at a zero count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_RING) |-> (r_count == '0))
        else $error("ringing with a nonzero count");

    // An accepted transaction holds the input ready low in the following cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input ready right after a transaction");

    // The divider only finishes while the sequencer waits on it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the wait state");

    // The delivered ones digit is a decimal digit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:12] < 4'd10))
        else $error("ones digit out of range");

endmodule
